>>> rtl/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg: shared types and constants for the voice allocator
// Request and response field widths, status codes and control state encoding.
// ----------------------------------------------------------------------------
package vat_pkg;

   // fixed field widths of the request and response channels
   localparam int CLIP_W  = 8;
   localparam int GAP_W   = 32;
   localparam int NOW_W   = 48;
   localparam int BUSY_W  = 4;
   localparam int VOICE_W = 2;
   localparam int STAT_W  = 2;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      ST_PLAYED    = 2'd0,
      ST_DISABLED  = 2'd1,
      ST_BAD_ID    = 2'd2,
      ST_THROTTLED = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_SCAN
   } ctl_state_type;

endpackage

>>> rtl/vat_req_if.sv
// ----------------------------------------------------------------------------
// vat_req_if: play request channel
// Valid/ready handshake carrying one play request.
// ----------------------------------------------------------------------------
interface vat_req_if;
   logic                        valid;
   logic                        ready;
   logic [vat_pkg::CLIP_W-1:0]  clip_id;
   logic [vat_pkg::GAP_W-1:0]   min_gap_ms;
   logic [vat_pkg::NOW_W-1:0]   now_ms;
   logic [vat_pkg::BUSY_W-1:0]  voice_busy;

   modport source (output valid, clip_id, min_gap_ms, now_ms, voice_busy, input ready);
   modport sink   (input valid, clip_id, min_gap_ms, now_ms, voice_busy, output ready);
endinterface

>>> rtl/vat_rsp_if.sv
// ----------------------------------------------------------------------------
// vat_rsp_if: allocation response channel
// Valid/ready handshake carrying the outcome of one play request.
// ----------------------------------------------------------------------------
interface vat_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vat_pkg::STAT_W-1:0]  status;
   logic [vat_pkg::VOICE_W-1:0] voice;
   logic                        stolen;
   logic [vat_pkg::CLIP_W-1:0]  clip_out;

   modport source (output valid, status, voice, stolen, clip_out, input ready);
   modport sink   (input valid, status, voice, stolen, clip_out, output ready);
endinterface

>>> rtl/vat_rr_pick.sv
// ----------------------------------------------------------------------------
// vat_rr_pick: round robin idle voice finder
// Finds the first idle voice at or after the start pointer, wrapping around.
// ----------------------------------------------------------------------------
module vat_rr_pick #(
   parameter int VOICES = 4,
   localparam int VIDX_W = $clog2(VOICES)
) (
   input  logic [VIDX_W-1:0]          start,
   input  logic [vat_pkg::BUSY_W-1:0] busy,
   output logic                       found,
   output logic [VIDX_W-1:0]          idx
);

   localparam int BUSY_N = (VOICES < vat_pkg::BUSY_W) ? VOICES : vat_pkg::BUSY_W;

   // voices beyond the busy field are always idle
   logic [VOICES-1:0] busy_ext;

   always_comb begin
      busy_ext = '0;
      for (int j = 0; j < BUSY_N; j++) begin
         busy_ext[j] = busy[j];
      end
   end

   // walk from the far end so the closest idle voice wins
   always_comb begin
      logic [VIDX_W:0]   sum;
      logic [VIDX_W-1:0] v;
      found = 1'b0;
      idx   = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         sum = {1'b0, start} + (VIDX_W+1)'(i);
         if (sum >= (VIDX_W+1)'(VOICES)) begin
            sum = sum - (VIDX_W+1)'(VOICES);
         end
         v = sum[VIDX_W-1:0];
         if (!busy_ext[v]) begin
            found = 1'b1;
            idx   = v;
         end
      end
   end

endmodule

>>> rtl/voice_allocator_with_throttle.sv
// ----------------------------------------------------------------------------
// voice_allocator_with_throttle: play request voice allocator
// Rejects disabled, bad-id and throttled requests; picks a voice round robin
// or steals the oldest one; returns one response per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. The accept cycle reads the clip's
// last-played time from the clip memory, the next cycle checks the throttle
// and picks an idle voice. When every voice is busy, the oldest start time is
// found by reading the voice memory one entry per cycle. A response waits in
// an output register, so the next request is taken while it is still pending;
// a request finishes only once that register is free. Last-played and start
// times come up as zero after reset through per-entry valid flags, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module voice_allocator_with_throttle #(
   parameter int VOICES    = 4,
   parameter int CLIPS     = 16,
   parameter int TIME_BITS = 48
) (
   input  logic       clock,
   input  logic       reset,
   vat_req_if.sink    req_if,
   vat_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   localparam int VIDX_W = $clog2(VOICES);
   localparam int CIDX_W = (CLIPS > 1) ? $clog2(CLIPS) : 1;

   // control and request registers
   vat_pkg::ctl_state_type      state_ff, state_in;
   logic                        enabled_ff;
   logic [vat_pkg::CLIP_W-1:0]  clip_ff;
   logic [vat_pkg::GAP_W-1:0]   gap_ff;
   logic [TIME_BITS-1:0]        now_ff;
   logic [vat_pkg::BUSY_W-1:0]  busy_ff;
   logic [VIDX_W-1:0]           next_voice_ff;
   logic [VIDX_W-1:0]           scan_idx_ff, scan_idx_in;
   logic [TIME_BITS-1:0]        best_time_ff, best_time_in;
   logic [VIDX_W-1:0]           best_idx_ff, best_idx_in;

   // clip last-played memory
   logic [TIME_BITS-1:0]        clip_mem [CLIPS];
   logic [TIME_BITS-1:0]        clip_q_ff;
   logic [CLIPS-1:0]            clip_vld_ff;

   // voice start-time memory
   logic [TIME_BITS-1:0]        voice_mem [VOICES];
   logic [TIME_BITS-1:0]        voice_q_ff;
   logic [VOICES-1:0]           voice_vld_ff;
   logic [VIDX_W-1:0]           voice_raddr_ff, voice_raddr_in;
   logic                        voice_rd_en;

   // response register
   logic                        rsp_vld_ff;
   vat_pkg::status_type         rsp_status_ff;
   logic [vat_pkg::VOICE_W-1:0] rsp_voice_ff;
   logic                        rsp_stolen_ff;
   logic [vat_pkg::CLIP_W-1:0]  rsp_clip_ff;

   logic                        accept;
   logic                        rsp_free;
   logic                        id_ok;
   logic [CIDX_W-1:0]           clip_idx;
   logic [TIME_BITS-1:0]        last_time;
   logic [TIME_BITS-1:0]        since_last;
   logic                        throttled;
   vat_pkg::status_type         check_status;
   logic                        rr_found;
   logic [VIDX_W-1:0]           rr_idx;
   logic [TIME_BITS-1:0]        voice_val;
   logic                        older;
   logic                        finish;
   vat_pkg::status_type         fin_status;
   logic [VIDX_W-1:0]           fin_pick;
   logic                        fin_stolen;

   assign accept   = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_vld_ff || rsp_if.ready;

   // enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_wr_en) begin
         enabled_ff <= csr_wr_data;
      end
   end

   // capture request fields
   always_ff @(posedge clock) begin
      if (accept) begin
         clip_ff <= req_if.clip_id;
         gap_ff  <= req_if.min_gap_ms;
         now_ff  <= TIME_BITS'(req_if.now_ms);
         busy_ff <= req_if.voice_busy;
      end
   end

   // throttle check against the last-played time read at accept
   assign id_ok      = {1'b0, clip_ff} < (vat_pkg::CLIP_W+1)'(CLIPS);
   assign clip_idx   = clip_ff[CIDX_W-1:0];
   assign last_time  = (id_ok && clip_vld_ff[clip_idx]) ? clip_q_ff : '0;
   assign since_last = now_ff - last_time;
   assign throttled  = (last_time != '0) && (since_last < TIME_BITS'(gap_ff));

   always_comb begin
      priority if (!enabled_ff) begin
         check_status = vat_pkg::ST_DISABLED;
      end else if (!id_ok) begin
         check_status = vat_pkg::ST_BAD_ID;
      end else if (throttled) begin
         check_status = vat_pkg::ST_THROTTLED;
      end else begin
         check_status = vat_pkg::ST_PLAYED;
      end
   end

   // round robin search for an idle voice
   vat_rr_pick #(
      .VOICES (VOICES)
   ) u_rr_pick (
      .start (next_voice_ff),
      .busy  (busy_ff),
      .found (rr_found),
      .idx   (rr_idx)
   );

   // oldest-start scan compare
   assign voice_val = voice_vld_ff[voice_raddr_ff] ? voice_q_ff : '0;
   assign older     = voice_val < best_time_ff;

   // controller: next state and per-cycle controls
   always_comb begin
      state_in       = state_ff;
      req_if.ready   = 1'b0;
      finish         = 1'b0;
      fin_status     = check_status;
      fin_pick       = rr_idx;
      fin_stolen     = 1'b0;
      voice_rd_en    = 1'b0;
      voice_raddr_in = '0;
      scan_idx_in    = scan_idx_ff;
      best_time_in   = best_time_ff;
      best_idx_in    = best_idx_ff;
      unique case (state_ff)
         vat_pkg::S_IDLE: begin
            req_if.ready = 1'b1;
            // prime the voice memory with entry zero for a possible scan
            voice_rd_en  = accept;
            if (accept) begin
               state_in = vat_pkg::S_LOOK;
            end
         end
         vat_pkg::S_LOOK: begin
            if (check_status != vat_pkg::ST_PLAYED || rr_found) begin
               if (rsp_free) begin
                  finish   = 1'b1;
                  state_in = vat_pkg::S_IDLE;
               end
            end else begin
               // all voices busy: start the oldest search at entry one
               best_time_in   = voice_val;
               best_idx_in    = '0;
               scan_idx_in    = VIDX_W'(1);
               voice_rd_en    = 1'b1;
               voice_raddr_in = VIDX_W'(1);
               state_in       = vat_pkg::S_SCAN;
            end
         end
         vat_pkg::S_SCAN: begin
            fin_status = vat_pkg::ST_PLAYED;
            fin_pick   = older ? scan_idx_ff : best_idx_ff;
            fin_stolen = 1'b1;
            if (scan_idx_ff == VIDX_W'(VOICES - 1)) begin
               if (rsp_free) begin
                  finish   = 1'b1;
                  state_in = vat_pkg::S_IDLE;
               end
            end else begin
               best_time_in   = older ? voice_val : best_time_ff;
               best_idx_in    = fin_pick;
               scan_idx_in    = scan_idx_ff + 1'b1;
               voice_rd_en    = 1'b1;
               voice_raddr_in = scan_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = vat_pkg::S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vat_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // scan registers
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      best_time_ff <= best_time_in;
      best_idx_ff  <= best_idx_in;
   end

   // clip memory: read at accept, write back on a played request
   // (write lands before the next accept, so no forwarding is needed)
   always_ff @(posedge clock) begin
      if (accept) begin
         clip_q_ff <= clip_mem[req_if.clip_id[CIDX_W-1:0]];
      end
      if (finish && fin_status == vat_pkg::ST_PLAYED) begin
         clip_mem[clip_idx] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_vld_ff <= '0;
      end else if (finish && fin_status == vat_pkg::ST_PLAYED) begin
         clip_vld_ff[clip_idx] <= 1'b1;
      end
   end

   // voice memory: one read per cycle during the scan, write on play
   always_ff @(posedge clock) begin
      if (voice_rd_en) begin
         voice_q_ff     <= voice_mem[voice_raddr_in];
         voice_raddr_ff <= voice_raddr_in;
      end
      if (finish && fin_status == vat_pkg::ST_PLAYED) begin
         voice_mem[fin_pick] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_vld_ff  <= '0;
         next_voice_ff <= '0;
      end else if (finish && fin_status == vat_pkg::ST_PLAYED) begin
         voice_vld_ff[fin_pick] <= 1'b1;
         next_voice_ff <= (fin_pick == VIDX_W'(VOICES - 1)) ? '0 : fin_pick + 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (finish) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= fin_status;
         rsp_clip_ff   <= clip_ff;
         if (fin_status == vat_pkg::ST_PLAYED) begin
            rsp_voice_ff  <= vat_pkg::VOICE_W'(fin_pick);
            rsp_stolen_ff <= fin_stolen;
         end else begin
            rsp_voice_ff  <= '0;
            rsp_stolen_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid    = rsp_vld_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.voice    = rsp_voice_ff;
   assign rsp_if.stolen   = rsp_stolen_ff;
   assign rsp_if.clip_out = rsp_clip_ff;

endmodule

>>> tb/tb_voice_allocator_with_throttle.sv
// ----------------------------------------------------------------------------
// tb_voice_allocator_with_throttle: self-checking bench for the voice allocator
// Drives play requests with random idle cycles on the request side and random
// stalls on the response side. A behavioral allocator predicts every response,
// and each response is compared field by field in order. Covered: the disabled
// engine, bad clip ids, throttle edges, time wrap, play at time zero,
// round-robin search and oldest-voice steal.
// ----------------------------------------------------------------------------
module tb_voice_allocator_with_throttle;

   localparam int VOICES    = 4;
   localparam int CLIPS     = 16;
   localparam int TIME_BITS = 48;
   localparam int CIDX_W    = 4;
   localparam int CLK_HALF  = 4;
   localparam int IDLE_PCT  = 17;
   localparam int TAIL_CYC  = 12;

   typedef struct packed {
      logic [vat_pkg::CLIP_W-1:0] clip_id;
      logic [vat_pkg::GAP_W-1:0]  min_gap_ms;
      logic [vat_pkg::NOW_W-1:0]  now_ms;
      logic [vat_pkg::BUSY_W-1:0] voice_busy;
   } play_req_type;

   typedef struct packed {
      vat_pkg::status_type         status;
      logic [vat_pkg::VOICE_W-1:0] voice;
      logic                        stolen;
      logic [vat_pkg::CLIP_W-1:0]  clip_out;
   } play_rsp_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   vat_req_if req_if ();
   vat_rsp_if rsp_if ();

   voice_allocator_with_throttle #(
      .VOICES    (VOICES),
      .CLIPS     (CLIPS),
      .TIME_BITS (TIME_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // allocator state mirrored by the bench
   logic                          engine_on;
   logic [vat_pkg::VOICE_W-1:0]   rr_next;
   logic [vat_pkg::NOW_W-1:0]     voice_started[VOICES];
   logic [vat_pkg::NOW_W-1:0]     clip_played_at[CLIPS];

   play_rsp_type                  pending_rsp[$];
   int                            mismatch_count;
   bit                            gaps_on;
   logic [vat_pkg::NOW_W-1:0]     sim_ms;

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // run limit
   initial begin
      #(2 * CLK_HALF * 400000);
      $display("tb_voice_allocator_with_throttle: FAIL");
      $finish;
   end

   // predict the response to one accepted request and advance the mirror state
   function automatic play_rsp_type allocate_voice(input play_req_type r);
      play_rsp_type                o;
      logic [vat_pkg::NOW_W-1:0]   last;
      logic [vat_pkg::NOW_W-1:0]   elapsed;
      logic [vat_pkg::VOICE_W-1:0] pick;
      logic [vat_pkg::VOICE_W-1:0] v;
      logic [CIDX_W-1:0]           cidx;
      bit                          found;
      o.status   = vat_pkg::ST_PLAYED;
      o.voice    = '0;
      o.stolen   = 1'b0;
      o.clip_out = r.clip_id;
      found      = 1'b0;
      pick       = '0;
      cidx       = r.clip_id[CIDX_W-1:0];
      if (!engine_on) begin
         o.status = vat_pkg::ST_DISABLED;
         return o;
      end
      if (r.clip_id >= CLIPS) begin
         o.status = vat_pkg::ST_BAD_ID;
         return o;
      end
      last    = clip_played_at[cidx];
      elapsed = r.now_ms - last;
      if (last != '0 &&
          elapsed < {{(vat_pkg::NOW_W-vat_pkg::GAP_W){1'b0}}, r.min_gap_ms}) begin
         o.status = vat_pkg::ST_THROTTLED;
         return o;
      end
      // round robin for an idle voice
      for (int i = 0; i < VOICES; i++) begin
         v = rr_next + i[vat_pkg::VOICE_W-1:0];
         if (!found && !r.voice_busy[v]) begin
            pick  = v;
            found = 1'b1;
         end
      end
      // all busy: oldest start wins, lowest index on ties
      if (!found) begin
         pick = '0;
         for (int i = 1; i < VOICES; i++)
            if (voice_started[i[vat_pkg::VOICE_W-1:0]] < voice_started[pick])
               pick = i[vat_pkg::VOICE_W-1:0];
         o.stolen = 1'b1;
      end
      rr_next              = pick + 1'b1;
      voice_started[pick]  = r.now_ms;
      clip_played_at[cidx] = r.now_ms;
      o.voice              = pick;
      return o;
   endfunction

   function automatic play_req_type make_req(input logic [vat_pkg::CLIP_W-1:0] clip,
                                             input logic [vat_pkg::GAP_W-1:0] gap,
                                             input logic [vat_pkg::NOW_W-1:0] now,
                                             input logic [vat_pkg::BUSY_W-1:0] busy);
      play_req_type r;
      r.clip_id    = clip;
      r.min_gap_ms = gap;
      r.now_ms     = now;
      r.voice_busy = busy;
      return r;
   endfunction

   // send one request; valid stays high afterwards unless a gap is taken
   task automatic send_request(input play_req_type r);
      if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.clip_id    <= r.clip_id;
      req_if.min_gap_ms <= r.min_gap_ms;
      req_if.now_ms     <= r.now_ms;
      req_if.voice_busy <= r.voice_busy;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_rsp.push_back(allocate_voice(r));
   endtask

   // drop valid and wait until every response has come back
   task automatic drain_requests();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYC) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      drain_requests();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      engine_on    = value;
   endtask

   // response side: random stalls, in-order compare
   initial begin
      play_rsp_type exp_rsp;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: response with no request outstanding, clip_out %0d",
                        $time, rsp_if.clip_out);
               mismatch_count++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_if.status !== exp_rsp.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, exp_rsp.status, rsp_if.status);
                  mismatch_count++;
               end
               if (rsp_if.voice !== exp_rsp.voice) begin
                  $display("%0t: voice expected %0d actual %0d",
                           $time, exp_rsp.voice, rsp_if.voice);
                  mismatch_count++;
               end
               if (rsp_if.stolen !== exp_rsp.stolen) begin
                  $display("%0t: stolen expected %0d actual %0d",
                           $time, exp_rsp.stolen, rsp_if.stolen);
                  mismatch_count++;
               end
               if (rsp_if.clip_out !== exp_rsp.clip_out) begin
                  $display("%0t: clip_out expected %0d actual %0d",
                           $time, exp_rsp.clip_out, rsp_if.clip_out);
                  mismatch_count++;
               end
            end
         end
         rsp_if.ready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
      end
   end

   // engine off after reset: every request is rejected, even bad ids
   task automatic test_disabled();
      send_request(make_req(8'd0, 32'd0, 48'd50, 4'h0));
      send_request(make_req(8'd15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF));
      send_request(make_req(8'd16, 32'd0, 48'd0, 4'h5));
      send_request(make_req(8'd255, 32'd7, 48'd1, 4'hA));
   endtask

   // directed corners with the engine on
   task automatic test_directed();
      write_enable(1'b1);
      // all busy straight after reset: every start time ties, voice 0 taken
      send_request(make_req(8'd0, 32'd0, 48'd100, 4'hF));
      send_request(make_req(8'd16, 32'd0, 48'd200, 4'h0));
      send_request(make_req(8'd255, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF));
      // throttle just inside and exactly at the gap
      send_request(make_req(8'd3, 32'd0, 48'd1000, 4'h0));
      send_request(make_req(8'd3, 32'd10, 48'd1005, 4'h0));
      send_request(make_req(8'd3, 32'd10, 48'd1010, 4'h2));
      // play at time zero leaves the clip looking never played
      send_request(make_req(8'd5, 32'hFFFF_FFFF, 48'd0, 4'h0));
      send_request(make_req(8'd5, 32'hFFFF_FFFF, 48'd1, 4'hF));
      // time wrap: small now after a last-played near the top
      send_request(make_req(8'd7, 32'd0, 48'hFFFF_FFFF_FFF0, 4'h7));
      send_request(make_req(8'd7, 32'd100, 48'd5, 4'h0));
      send_request(make_req(8'd7, 32'd0, 48'd10, 4'hE));
      // now before last: difference wraps large, not throttled
      send_request(make_req(8'd7, 32'hFFFF_FFFF, 48'd5, 4'h0));
      // top clip id, top time, top gap
      send_request(make_req(8'd15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF));
      send_request(make_req(8'd15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF));
      send_request(make_req(8'd15, 32'd1, 48'hFFFF_FFFF_FFFF, 4'h0));
      send_request(make_req(8'd15, 32'd0, 48'hFFFF_FFFF_FFFF, 4'hB));
      send_request(make_req(8'd8, 32'd20, 48'd3000, 4'h5));
      send_request(make_req(8'd9, 32'd20, 48'd3001, 4'hF));
      send_request(make_req(8'd10, 32'd20, 48'd3002, 4'hF));
      send_request(make_req(8'd8, 32'd20, 48'd3019, 4'h0));
      send_request(make_req(8'd8, 32'd20, 48'd3020, 4'h0));
   endtask

   // mostly valid clips on a rising clock; some noise in ids, gaps and times
   task automatic test_random_traffic(input int count);
      play_req_type r;
      int           roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         r.clip_id = (roll < 8) ? 8'($urandom_range(16, 255)) : 8'($urandom_range(0, 15));
         sim_ms = sim_ms + vat_pkg::NOW_W'($urandom_range(0, 40));
         roll = $urandom_range(99);
         if (roll < 3)
            sim_ms = vat_pkg::NOW_W'({$urandom, $urandom});
         else if (roll < 4)
            sim_ms = '0;
         r.now_ms = sim_ms;
         roll = $urandom_range(99);
         if (roll < 20)
            r.min_gap_ms = '0;
         else if (roll < 50)
            r.min_gap_ms = $urandom_range(0, 40);
         else if (roll < 90)
            r.min_gap_ms = $urandom_range(0, 120);
         else
            r.min_gap_ms = $urandom;
         roll = $urandom_range(99);
         r.voice_busy = (roll < 30) ? 4'hF : (roll < 40) ? 4'h0 : 4'($urandom_range(0, 15));
         send_request(r);
      end
   endtask

   initial begin
      mismatch_count = 0;
      gaps_on        = 1'b1;
      sim_ms         = 48'd5000;
      engine_on      = 1'b0;
      rr_next        = '0;
      for (int i = 0; i < VOICES; i++) voice_started[i[vat_pkg::VOICE_W-1:0]] = '0;
      for (int i = 0; i < CLIPS; i++) clip_played_at[i[CIDX_W-1:0]] = '0;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= 1'b0;
      req_if.valid      <= 1'b0;
      req_if.clip_id    <= '0;
      req_if.min_gap_ms <= '0;
      req_if.now_ms     <= '0;
      req_if.voice_busy <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled();
      test_directed();
      test_random_traffic(600);
      // long stretch with no idling on either side
      gaps_on = 1'b0;
      test_random_traffic(300);
      gaps_on = 1'b1;
      write_enable(1'b0);
      test_random_traffic(100);
      write_enable(1'b1);
      test_random_traffic(700);

      drain_requests();
      if (mismatch_count == 0) begin
         $display("tb_voice_allocator_with_throttle: PASS");
      end else begin
         $display("tb_voice_allocator_with_throttle: FAIL");
      end
      $finish;
   end

endmodule
